@@ src/first_fit_page_run_allocator_assert.svh @@
// Assertion macros used by the allocator's controller RTL (ffpra_ctrl).
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FFPRA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FFPRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

@@ src/ffpra_pkg.sv @@
package ffpra_pkg;

  localparam int TABLE_PAGES = 256;
  localparam int PAGE_SHIFT  = 12;

  localparam int IDX_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  // Wide enough for a page count up to TABLE_PAGES itself and for a 9-bit count.
  localparam int LEN_W = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;

  localparam int COUNT_W     = 9;
  localparam int ADDR_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_IGNORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 1'b1;

  typedef struct packed {
    logic               free;
    logic [COUNT_W-1:0] run_len;
  } page_ent_t;

  localparam int ENT_W = COUNT_W + 1;

  typedef struct packed {
    logic [ADDR_W-1:0]  region_base;
    logic [COUNT_W-1:0] pages_in_use;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   run_address;
  } result_t;

endpackage

@@ src/ffpra_ram.sv @@
module ffpra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ffpra_ctrl.sv @@
`include "first_fit_page_run_allocator_assert.svh"

module ffpra_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ffpra_pkg::cfg_t                   cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [ffpra_pkg::COUNT_W-1:0]     in_count,
  input  logic [ffpra_pkg::ADDR_W-1:0]      in_addr,
  output logic                              res_valid,
  input  logic                              res_ready,
  output ffpra_pkg::result_t                res,
  output logic                              mem_we,
  output logic [ffpra_pkg::IDX_W-1:0]       mem_waddr,
  output logic [ffpra_pkg::ENT_W-1:0]       mem_wdata,
  output logic                              mem_re,
  output logic [ffpra_pkg::IDX_W-1:0]       mem_raddr,
  input  logic [ffpra_pkg::ENT_W-1:0]       mem_rdata
);

  import ffpra_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_FCALC = 3'd4;
  localparam logic [2:0] S_FWAIT = 3'd5;
  localparam logic [2:0] S_FREL  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [LEN_W-1:0]   ptr_r, ptr_nxt;
  logic               rvld_r, rvld_nxt;
  logic [IDX_W-1:0]   chk_r, chk_nxt;
  logic               op_r, op_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [COUNT_W-1:0] seen_r, seen_nxt;
  logic [IDX_W-1:0]   start_r, start_nxt;
  logic [LEN_W-1:0]   n_r, n_nxt;
  result_t            res_r, res_nxt;

  page_ent_t          rd_ent;
  page_ent_t          wr_ent;
  logic [LEN_W-1:0]   used_len;
  logic [ADDR_W-1:0]  offset;
  logic [ADDR_W:0]    idx_full;
  logic               below_base;
  logic               beyond_table;
  logic [COUNT_W-1:0] seen_inc;
  logic [IDX_W-1:0]   start_cur;
  logic               found;
  logic [LEN_W-1:0]   rem_pages;
  logic [LEN_W-1:0]   run_n;
  logic [LEN_W-1:0]   n_eff;
  logic [ADDR_W-1:0]  mark_addr;

  assign rd_ent    = page_ent_t'(mem_rdata);
  assign mem_wdata = wr_ent;
  assign res       = res_r;

  assign used_len = (LEN_W'(cfg.pages_in_use) > LEN_W'(TABLE_PAGES)) ?
                    LEN_W'(TABLE_PAGES) : LEN_W'(cfg.pages_in_use);

  // A free address rounds up to the next page boundary.
  assign below_base   = addr_r < cfg.region_base;
  assign offset       = addr_r - cfg.region_base;
  assign idx_full     = (ADDR_W + 1)'(offset >> PAGE_SHIFT) +
                        (ADDR_W + 1)'(|offset[PAGE_SHIFT-1:0]);
  assign beyond_table = idx_full >= (ADDR_W + 1)'(TABLE_PAGES);

  assign seen_inc  = seen_r + COUNT_W'(1);
  assign start_cur = (seen_r == '0) ? chk_r : start_r;
  assign found     = rvld_r && rd_ent.free && (seen_inc == count_r);

  assign rem_pages = LEN_W'(TABLE_PAGES) - ptr_r;
  assign run_n     = LEN_W'(rd_ent.run_len);
  assign n_eff     = (run_n > rem_pages) ? rem_pages : run_n;

  assign mark_addr = cfg.region_base + (ADDR_W'(start_r) << PAGE_SHIFT);

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    rvld_nxt  = rvld_r;
    chk_nxt   = chk_r;
    op_nxt    = op_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    seen_nxt  = seen_r;
    start_nxt = start_r;
    n_nxt     = n_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = ptr_r[IDX_W-1:0];
    wr_ent    = '{free: 1'b1, run_len: '0};
    mem_re    = 1'b0;
    mem_raddr = ptr_r[IDX_W-1:0];
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + LEN_W'(1);
        if (ptr_r == LEN_W'(TABLE_PAGES - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_op;
          count_nxt = in_count;
          addr_nxt  = in_addr;
          ptr_nxt   = '0;
          seen_nxt  = '0;
          rvld_nxt  = 1'b0;
          if (in_op == OP_FREE) begin
            state_nxt = S_FCALC;
          end else if (in_count == '0) begin
            res_nxt   = '{status: ST_ALLOC_FAIL, run_address: '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Reads are issued one page ahead of the page being judged.
        if (rvld_r) begin
          seen_nxt = rd_ent.free ? seen_inc : '0;
          if (rd_ent.free) begin
            start_nxt = start_cur;
          end
        end
        if (found) begin
          rvld_nxt  = 1'b0;
          ptr_nxt   = LEN_W'(start_cur);
          n_nxt     = LEN_W'(count_r);
          state_nxt = S_MARK;
        end else if (ptr_r < used_len) begin
          mem_re   = 1'b1;
          chk_nxt  = ptr_r[IDX_W-1:0];
          rvld_nxt = 1'b1;
          ptr_nxt  = ptr_r + LEN_W'(1);
        end else begin
          rvld_nxt = 1'b0;
          if (!rvld_r) begin
            res_nxt   = '{status: ST_ALLOC_FAIL, run_address: '0};
            state_nxt = S_DONE;
          end
        end
      end
      S_MARK: begin
        mem_we  = 1'b1;
        wr_ent  = '{free: 1'b0, run_len: count_r};
        ptr_nxt = ptr_r + LEN_W'(1);
        n_nxt   = n_r - LEN_W'(1);
        if (n_r == LEN_W'(1)) begin
          res_nxt   = '{status: ST_DONE, run_address: mark_addr};
          state_nxt = S_DONE;
        end
      end
      S_FCALC: begin
        if (below_base || beyond_table) begin
          res_nxt   = '{status: ST_FREE_IGNORED, run_address: '0};
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_full[IDX_W-1:0];
          ptr_nxt   = LEN_W'(idx_full);
          state_nxt = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (n_eff == '0) begin
          res_nxt   = '{status: ST_DONE, run_address: '0};
          state_nxt = S_DONE;
        end else begin
          n_nxt     = n_eff;
          state_nxt = S_FREL;
        end
      end
      S_FREL: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + LEN_W'(1);
        n_nxt   = n_r - LEN_W'(1);
        if (n_r == LEN_W'(1)) begin
          res_nxt   = '{status: ST_DONE, run_address: '0};
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r   <= '0;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      rvld_r  <= rvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r   <= chk_nxt;
    op_r    <= op_nxt;
    count_r <= count_nxt;
    addr_r  <= addr_nxt;
    seen_r  <= seen_nxt;
    start_r <= start_nxt;
    n_r     <= n_nxt;
    res_r   <= res_nxt;
  end

  `FFPRA_ASSERT_IMPLIES(a_mark_takes_page, clk, rst_n, state_r == S_MARK, mem_we && !wr_ent.free)
  `FFPRA_ASSERT_IMPLIES(a_no_read_during_write, clk, rst_n, mem_we, !mem_re)
  `FFPRA_ASSERT_IMPLIES(a_free_gives_no_address, clk, rst_n, res_valid && op_r == OP_FREE, res_r.run_address == '0)
  `FFPRA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)

endmodule

@@ src/first_fit_page_run_allocator.sv @@
// First-fit page run allocator. The page table lives in a single-port-per-direction
// RAM, one entry per page holding a free flag and a run length. After reset the
// block clears the table and accepts no beat until it is done; configuration
// writes are taken at any time but belong in idle periods. Items are handled one
// at a time and every page access goes through the RAM one entry a cycle. An
// allocate scans at most pages_in_use pages, capped at TABLE_PAGES, for a fit and
// then marks the pages of the run; a zero-count allocate fails without a scan. A
// free releases the stored run length clipped at the table end, or is ignored
// when its address lies outside the table. Results wait in an output register,
// so the next beat is accepted while a result is still held.
module first_fit_page_run_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: page_count[8:0], address[40:9], zero fill [47:41].
  input  logic [ffpra_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Fields from bit 0: op.
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: run_address[31:0].
  output logic [ffpra_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Fields from bit 0: status[1:0].
  output logic [ffpra_pkg::STATUS_W-1:0]      out_tuser,
  input  logic                                cfg_we,
  input  logic [ffpra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffpra_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import ffpra_pkg::*;

  cfg_t                cfg_r;
  logic                res_valid;
  logic                res_ready;
  result_t             res;
  logic                out_vld_r;
  result_t             out_res_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENT_W-1:0]    mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  logic [ENT_W-1:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.region_base  <= '0;
      cfg_r.pages_in_use <= COUNT_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REGION_BASE:  cfg_r.region_base  <= cfg_wdata;
        REG_PAGES_IN_USE: cfg_r.pages_in_use <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ffpra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[0]),
    .in_count  (in_tdata[COUNT_W-1:0]),
    .in_addr   (in_tdata[COUNT_W+ADDR_W-1:COUNT_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ffpra_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_PAGES)
  ) u_page_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_ready) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r.run_address;
  assign out_tuser  = out_res_r.status;

endmodule
